>>> hw/rtl/mswd_pkg.sv
`default_nettype none

package mswd_pkg;

    // Scan word width and switch count
    localparam int SCAN_W       = 16;
    localparam int NUM_SWITCHES = 16;
    localparam int LANES        = (NUM_SWITCHES > SCAN_W) ? SCAN_W : NUM_SWITCHES;
    localparam int IDX_W        = $clog2(SCAN_W);
    localparam int CNT_W        = 4;
    localparam int ID_W         = 8;
    localparam int CFG_W        = 8;

    localparam logic [CNT_W-1:0] CNT_MAX     = {CNT_W{1'b1}};
    localparam logic [CNT_W-1:0] LIMIT_RESET = CNT_W'(5);
    localparam logic [ID_W-1:0]  BASE_RESET  = '0;

    // Configuration register indexes
    localparam logic REG_BASE_ID     = 1'b0;
    localparam logic REG_COUNT_LIMIT = 1'b1;

    // One classified scan waiting for the reporter
    typedef struct packed {
        logic [SCAN_W-1:0] changed;
        logic [SCAN_W-1:0] levels;
    } t_entry;

    // Queue status toward its consumer
    typedef struct packed {
        logic full;
        logic not_empty;
    } t_q_status;

endpackage

`default_nettype wire

>>> hw/rtl/multi_switch_debounce_reporter.sv
// Multi-switch debouncer with change reporting.
// Input channel (i_valid / o_stall): one transaction is one scan of the raw
// level of all switches, bit i being switch i. Every scan updates the per
// switch mismatch counters in the cycle it is accepted.
// Output channel (o_valid / i_stall): one transaction per switch whose
// debounced level changed, lowest index first, o_last on the final one; a
// scan with no change gives a single no-change transaction with o_last set.
// A scan goes through a queue entry, the reporter's mask register and the
// output register. The reporter emits one result per cycle while the
// receiver does not stall, and loads a scan from the two-entry queue only
// when done with the last result of the previous scan, in a step of its own.
// Scans are taken every cycle while the queue has room.
// Configuration (i_cfg_we, i_cfg_index, i_cfg_data): index 0 is base_id,
// index 1 is count_limit; write only while the block is idle.
// Reset clears debounced levels and counters, sets base_id to 0 and
// count_limit to 5, and empties the queue and output register.
// While the receiver stalls, the output transaction holds and the queue
// fills; o_stall rises once both queue entries are occupied.
`default_nettype none

module multi_switch_debounce_reporter (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire logic                          i_valid,
    output      logic                          o_stall,
    input  wire logic [mswd_pkg::SCAN_W-1:0]   i_raw_levels,
    output      logic                          o_valid,
    input  wire logic                          i_stall,
    output      logic                          o_event_valid,
    output      logic [mswd_pkg::ID_W-1:0]     o_switch_id,
    output      logic                          o_new_level,
    output      logic                          o_last,
    output      logic [mswd_pkg::SCAN_W-1:0]   o_debounced_levels,
    input  wire logic                          i_cfg_we,
    input  wire logic                          i_cfg_index,
    input  wire logic [mswd_pkg::CFG_W-1:0]    i_cfg_data
);

    logic [mswd_pkg::ID_W-1:0]  r_base_id;
    logic [mswd_pkg::CNT_W-1:0] r_count_limit;
    logic                       in_accept;
    logic                       pop;
    mswd_pkg::t_entry           front_entry;
    mswd_pkg::t_entry           q_entry;
    mswd_pkg::t_q_status        q_status;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_base_id     <= mswd_pkg::BASE_RESET;
            r_count_limit <= mswd_pkg::LIMIT_RESET;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                mswd_pkg::REG_BASE_ID:     r_base_id     <= i_cfg_data;
                mswd_pkg::REG_COUNT_LIMIT: r_count_limit <= i_cfg_data[mswd_pkg::CNT_W-1:0];
                default: ;
            endcase
        end
    end

    assign o_stall   = q_status.full;
    assign in_accept = i_valid && !q_status.full;

    mswd_front u_front (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_accept      (in_accept),
        .i_raw_levels  (i_raw_levels),
        .i_count_limit (r_count_limit),
        .o_entry       (front_entry)
    );

    mswd_queue u_queue (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_push   (in_accept),
        .i_entry  (front_entry),
        .i_pop    (pop),
        .o_entry  (q_entry),
        .o_status (q_status)
    );

    mswd_back u_back (
        .i_clk              (i_clk),
        .i_rst_n            (i_rst_n),
        .i_entry            (q_entry),
        .i_status           (q_status),
        .o_pop              (pop),
        .i_base_id          (r_base_id),
        .o_valid            (o_valid),
        .i_stall            (i_stall),
        .o_event_valid      (o_event_valid),
        .o_switch_id        (o_switch_id),
        .o_new_level        (o_new_level),
        .o_last             (o_last),
        .o_debounced_levels (o_debounced_levels)
    );

    // A no-change transaction always closes its scan
    a_nochange_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && !o_event_valid) |-> o_last)
        else $error("no-change transaction without last");

    // A reported switch level must match the debounced word it carries
    a_level_match: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_event_valid)
            |-> (o_debounced_levels[mswd_pkg::IDX_W'(o_switch_id - r_base_id)]
                 == o_new_level))
        else $error("event level disagrees with debounced levels");

    // The reporter never pulls from an empty queue
    a_pop_nonempty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        pop |-> q_status.not_empty)
        else $error("pop from empty queue");

endmodule

`default_nettype wire

>>> hw/rtl/mswd_front.sv
`default_nettype none

module mswd_front (
    input  wire logic                            i_clk,
    input  wire logic                            i_rst_n,
    input  wire logic                            i_accept,
    input  wire logic [mswd_pkg::SCAN_W-1:0]     i_raw_levels,
    input  wire logic [mswd_pkg::CNT_W-1:0]      i_count_limit,
    output      mswd_pkg::t_entry                o_entry
);

    logic [mswd_pkg::SCAN_W-1:0] r_stable;
    logic [mswd_pkg::SCAN_W-1:0] n_stable;
    logic [mswd_pkg::CNT_W-1:0]  r_count [mswd_pkg::SCAN_W];
    logic [mswd_pkg::CNT_W-1:0]  n_count [mswd_pkg::SCAN_W];
    logic [mswd_pkg::SCAN_W-1:0] changed;

    // Every lane is independent: count mismatches, flip when over the limit
    always_comb begin
        logic [mswd_pkg::CNT_W-1:0] c;
        c        = '0;
        n_stable = r_stable;
        changed  = '0;
        for (int i = 0; i < mswd_pkg::SCAN_W; i++) begin
            n_count[i] = r_count[i];
            c          = r_count[i];
            if (i < mswd_pkg::LANES && i_raw_levels[i] != r_stable[i]) begin
                if (c != mswd_pkg::CNT_MAX) begin
                    c = c + 1'b1;
                end
                if (c > i_count_limit) begin
                    n_stable[i] = i_raw_levels[i];
                    changed[i]  = 1'b1;
                    c           = '0;
                end
                n_count[i] = c;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_stable <= '0;
            for (int i = 0; i < mswd_pkg::SCAN_W; i++) begin
                r_count[i] <= '0;
            end
        end else if (i_accept) begin
            r_stable <= n_stable;
            for (int i = 0; i < mswd_pkg::SCAN_W; i++) begin
                r_count[i] <= n_count[i];
            end
        end
    end

    assign o_entry.changed = changed;
    assign o_entry.levels  = n_stable;

endmodule

`default_nettype wire

>>> hw/rtl/mswd_queue.sv
`default_nettype none

module mswd_queue (
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    input  wire logic                 i_push,
    input  wire mswd_pkg::t_entry     i_entry,
    input  wire logic                 i_pop,
    output mswd_pkg::t_entry          o_entry,
    output mswd_pkg::t_q_status       o_status
);

    mswd_pkg::t_entry r_mem [2];
    logic             r_wr_ptr;
    logic             r_rd_ptr;
    logic [1:0]       r_fill;
    logic             do_push;
    logic             do_pop;

    assign do_push = i_push && (r_fill != 2'd2);
    assign do_pop  = i_pop && (r_fill != 2'd0);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= 1'b0;
            r_rd_ptr <= 1'b0;
            r_fill   <= '0;
        end else begin
            if (do_push) begin
                r_wr_ptr <= ~r_wr_ptr;
            end
            if (do_pop) begin
                r_rd_ptr <= ~r_rd_ptr;
            end
            case ({do_push, do_pop})
                2'b10:   r_fill <= r_fill + 2'd1;
                2'b01:   r_fill <= r_fill - 2'd1;
                default: r_fill <= r_fill;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr_ptr] <= i_entry;
        end
    end

    assign o_entry            = r_mem[r_rd_ptr];
    assign o_status.full      = (r_fill == 2'd2);
    assign o_status.not_empty = (r_fill != 2'd0);

endmodule

`default_nettype wire

>>> hw/rtl/mswd_back.sv
`default_nettype none

module mswd_back (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire mswd_pkg::t_entry              i_entry,
    input  wire mswd_pkg::t_q_status           i_status,
    output      logic                          o_pop,
    input  wire logic [mswd_pkg::ID_W-1:0]     i_base_id,
    output      logic                          o_valid,
    input  wire logic                          i_stall,
    output      logic                          o_event_valid,
    output      logic [mswd_pkg::ID_W-1:0]     o_switch_id,
    output      logic                          o_new_level,
    output      logic                          o_last,
    output      logic [mswd_pkg::SCAN_W-1:0]   o_debounced_levels
);

    logic                          r_busy;
    logic                          n_busy;
    logic [mswd_pkg::SCAN_W-1:0]   r_mask;
    logic [mswd_pkg::SCAN_W-1:0]   n_mask;
    logic [mswd_pkg::SCAN_W-1:0]   r_levels;
    logic [mswd_pkg::SCAN_W-1:0]   n_levels;
    logic                          r_out_valid;
    logic                          n_out_valid;
    logic                          r_event_valid;
    logic                          n_event_valid;
    logic [mswd_pkg::ID_W-1:0]     r_switch_id;
    logic [mswd_pkg::ID_W-1:0]     n_switch_id;
    logic                          r_new_level;
    logic                          n_new_level;
    logic                          r_last;
    logic                          n_last;
    logic [mswd_pkg::SCAN_W-1:0]   r_out_levels;
    logic [mswd_pkg::SCAN_W-1:0]   n_out_levels;
    logic [mswd_pkg::IDX_W-1:0]    idx;
    logic [mswd_pkg::SCAN_W-1:0]   rest;
    logic                          out_free;
    logic                          emit;

    // Lowest pending switch goes first
    always_comb begin
        idx = '0;
        for (int i = mswd_pkg::SCAN_W - 1; i >= 0; i--) begin
            if (r_mask[i]) begin
                idx = mswd_pkg::IDX_W'(i);
            end
        end
    end

    assign rest     = r_mask & (r_mask - 1'b1);
    assign out_free = !r_out_valid || !i_stall;
    assign emit     = r_busy && out_free;
    assign o_pop    = !r_busy && i_status.not_empty;

    always_comb begin
        n_busy        = r_busy;
        n_mask        = r_mask;
        n_levels      = r_levels;
        n_out_valid   = r_out_valid;
        n_event_valid = r_event_valid;
        n_switch_id   = r_switch_id;
        n_new_level   = r_new_level;
        n_last        = r_last;
        n_out_levels  = r_out_levels;
        if (emit) begin
            n_out_valid   = 1'b1;
            n_event_valid = (r_mask != '0);
            n_switch_id   = (r_mask != '0)
                          ? i_base_id + mswd_pkg::ID_W'(idx) : '0;
            n_new_level   = (r_mask != '0) ? r_levels[idx] : 1'b0;
            n_last        = (rest == '0);
            n_out_levels  = r_levels;
            n_mask        = rest;
            if (rest == '0) begin
                n_busy = 1'b0;
            end
        end else if (r_out_valid && !i_stall) begin
            n_out_valid = 1'b0;
        end
        if (o_pop) begin
            n_busy   = 1'b1;
            n_mask   = i_entry.changed;
            n_levels = i_entry.levels;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy      <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_busy      <= n_busy;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_mask        <= n_mask;
        r_levels      <= n_levels;
        r_event_valid <= n_event_valid;
        r_switch_id   <= n_switch_id;
        r_new_level   <= n_new_level;
        r_last        <= n_last;
        r_out_levels  <= n_out_levels;
    end

    assign o_valid            = r_out_valid;
    assign o_event_valid      = r_event_valid;
    assign o_switch_id        = r_switch_id;
    assign o_new_level        = r_new_level;
    assign o_last             = r_last;
    assign o_debounced_levels = r_out_levels;

endmodule

`default_nettype wire
